// ----- rtl/fce_pkg.sv -----
// package for the field convergence error check
// constants, register indexes, mode codes and the controller/datapath command and status structs
// no dependencies
`default_nettype none
package fce_pkg;
	localparam int MAX_NODES = 4096;
	localparam int NODE_W = 13;
	localparam int DATA_W = 32;
	localparam int SUM_W = 64;

	// register indexes
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_TEMP_MAX = 3'd1;
	localparam logic [2:0] REG_TEMP_MIN = 3'd2;
	localparam logic [2:0] REG_NODE_COUNT = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;

	// mode codes
	localparam logic [2:0] MODE_MAX = 3'd0;
	localparam logic [2:0] MODE_NMAX = 3'd1;
	localparam logic [2:0] MODE_RMS = 3'd2;
	localparam logic [2:0] MODE_MEAN = 3'd3;
	localparam logic [2:0] MODE_NMEAN = 3'd4;

	// controller to datapath commands
	typedef struct packed {
		logic accum;      // fold the item into the accumulators
		logic fin_load;   // latch numerator and divisor, clear accumulators
		logic div_step;   // one restoring divide step
		logic sqrt_step;  // one square root step
		logic done;       // form the result and strobe it
	} fce_cmd_t;

	typedef struct packed {
		logic div_last;
		logic sqrt_last;
		logic need_sqrt;
	} fce_sts_t;
endpackage
`default_nettype wire

// ----- rtl/fce_ctrl.sv -----
// controller for the field convergence error check
// sequences accumulate, finish divide and square root; uses fce_pkg
`default_nettype none
module fce_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic last_node,
	input wire fce_pkg::fce_sts_t sts,
	output logic busy,
	output fce_pkg::fce_cmd_t cmd
);
	import fce_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic take;

	assign take = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// commands
	always_comb begin
		cmd = '0;
		cmd.accum = take;
		cmd.fin_load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.done = (state_q == ST_DONE);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take && last_node) state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: if (sts.div_last) state_q <= sts.need_sqrt ? ST_SQRT : ST_DONE;
				ST_SQRT: if (sts.sqrt_last) state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/fce_dp.sv -----
// datapath for the field convergence error check
// accumulators, config registers, serial divider and square root; uses fce_pkg
`default_nettype none
module fce_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire fce_pkg::fce_cmd_t cmd,
	output fce_pkg::fce_sts_t sts,
	input wire logic cfg_valid,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic signed [31:0] new_value,
	input wire logic signed [31:0] old_value,
	output logic [31:0] error_metric,
	output logic converged,
	output logic bad_divisor,
	output logic result_valid
);
	import fce_pkg::*;

	logic [2:0] mode_q;
	logic signed [31:0] temp_max_q, temp_min_q;
	logic [NODE_W-1:0] node_count_q;
	logic [31:0] tolerance_q;
	logic [31:0] rmax_q;
	logic [SUM_W-1:0] rsum_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MAX;
			temp_max_q <= 32'sd65536;
			temp_min_q <= '0;
			node_count_q <= 13'd1;
			tolerance_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[2:0];
				REG_TEMP_MAX: temp_max_q <= cfg_data;
				REG_TEMP_MIN: temp_min_q <= cfg_data;
				REG_NODE_COUNT: node_count_q <= cfg_data[NODE_W-1:0];
				REG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// difference and its magnitude
	logic signed [32:0] diff;
	logic [32:0] adiff;
	logic [31:0] ad32;
	logic [SUM_W-1:0] addend;
	logic [SUM_W:0] sum_ext;
	assign diff = 33'(new_value) - 33'(old_value);
	assign adiff = diff[32] ? 33'(-diff) : diff;
	assign ad32 = adiff[32] ? '1 : adiff[31:0];
	always_comb begin
		if (mode_q == MODE_RMS) addend = adiff[32] ? '1 : 64'(ad32) * 64'(ad32);
		else addend = 64'(adiff);
	end
	assign sum_ext = 65'(rsum_q) + 65'(addend);

	// effective mode, span and node count
	logic [2:0] m;
	logic signed [32:0] span;
	logic [31:0] span_u;
	logic [NODE_W-1:0] nodes;
	logic bad;
	assign m = (mode_q > MODE_NMEAN) ? MODE_MAX : mode_q;
	assign span = 33'(temp_max_q) - 33'(temp_min_q);
	assign span_u = (span > 0) ? span[31:0] : '0;
	assign nodes = (node_count_q > 13'(MAX_NODES)) ? 13'(MAX_NODES) : node_count_q;
	always_comb begin
		unique case (m)
			MODE_NMAX: bad = (span_u == '0);
			MODE_RMS, MODE_MEAN: bad = (nodes == '0);
			MODE_NMEAN: bad = (nodes == '0) || (span_u == '0);
			default: bad = 1'b0;
		endcase
	end

	// divider: numerator up to 80 bits (sum shifted by 16), quotient kept 80 bits
	localparam int NUM_W = 80;
	localparam int DEN_W = 45;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [6:0] cnt_q;
	logic [2:0] fm_q;
	logic bad_q;
	logic [DEN_W-1:0] den_sel;
	logic [NUM_W-1:0] num_sel;
	logic [DEN_W:0] rem_sh, rem_sub;

	always_comb begin
		unique case (m)
			MODE_NMAX: begin
				num_sel = NUM_W'({rmax_q, 16'h0000});
				den_sel = DEN_W'(span_u);
			end
			MODE_RMS, MODE_MEAN: begin
				num_sel = NUM_W'(rsum_q);
				den_sel = DEN_W'(nodes);
			end
			MODE_NMEAN: begin
				num_sel = {rsum_q, 16'h0000};
				den_sel = DEN_W'(span_u) * DEN_W'(nodes);
			end
			default: begin
				num_sel = NUM_W'(rmax_q);
				den_sel = DEN_W'(1);
			end
		endcase
		if (bad) den_sel = DEN_W'(1);
	end

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - (DEN_W+1)'(den_q);

	// square root, two bits a step
	logic [SUM_W-1:0] sv_q;
	logic [SUM_W-1:0] sres_q;
	logic [SUM_W-1:0] sbit_q;
	logic [SUM_W-1:0] strial;
	assign strial = sres_q + sbit_q;

	assign sts.div_last = (cnt_q == 7'(NUM_W-1));
	assign sts.sqrt_last = (sbit_q[1:0] != 2'b00) || (sbit_q == '0);
	assign sts.need_sqrt = (fm_q == MODE_RMS) && !bad_q;

	// accumulators and serial units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmax_q <= '0;
			rsum_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.done;
			if (cmd.accum) begin
				if (ad32 > rmax_q) rmax_q <= ad32;
				rsum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			end
			if (cmd.fin_load) begin
				rmax_q <= '0;
				rsum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			quo_q <= num_sel;
			den_q <= den_sel;
			rem_q <= '0;
			cnt_q <= '0;
			fm_q <= m;
			bad_q <= bad;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + 7'd1;
			if (rem_sh >= (DEN_W+1)'(den_q)) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
			sres_q <= '0;
			sbit_q <= 64'h4000_0000_0000_0000;
		end
		if (cmd.div_step && sts.div_last) begin
			sv_q <= {quo_q[SUM_W-2:0], (rem_sh >= (DEN_W+1)'(den_q))};
		end
		if (cmd.sqrt_step) begin
			if (sv_q >= strial) begin
				sv_q <= sv_q - strial;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
	end

	// result formation
	logic [31:0] metric;
	always_comb begin
		if (bad_q) metric = '0;
		else if (fm_q == MODE_RMS) metric = sres_q[31:0];
		else if (quo_q[NUM_W-1:32] != '0) metric = '1;
		else metric = quo_q[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			error_metric <= metric;
			bad_divisor <= bad_q;
			converged <= !bad_q && (metric <= tolerance_q);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/field_convergence_error_check.sv -----
// Field convergence error check, top level.
// Items: start/busy command channel carrying new_value, old_value, last_node.
// An item is taken when start is high and busy is low; an item with last_node
// low is folded into the running maximum and sum, so such items may follow
// each other every cycle.
// On the last item of a field the block goes busy: a load state, then a serial
// restoring divider (one quotient bit per cycle), then a square root unit in
// rms mode, and a done state to form the result. The result shows on
// error_metric, converged, bad_divisor with result_valid high for one cycle.
// Busy covers the load, divide, square root and done states, and the next item
// may be taken in the result cycle.
// The receiver cannot stall; results are never held.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while idle.
// Reset (arst_n low) clears accumulators and loads default register values.
// Uses fce_pkg, fce_ctrl, fce_dp.
`default_nettype none
module field_convergence_error_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [31:0] new_value,
	input wire logic signed [31:0] old_value,
	input wire logic last_node,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic result_valid,
	output logic [31:0] error_metric,
	output logic converged,
	output logic bad_divisor
);
	import fce_pkg::*;

	fce_cmd_t cmd;
	fce_sts_t sts;

	assign cfg_ready = 1'b1;

	fce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_node(last_node),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	fce_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.new_value(new_value), .old_value(old_value),
		.error_metric(error_metric), .converged(converged),
		.bad_divisor(bad_divisor), .result_valid(result_valid)
	);
endmodule
`default_nettype wire

// ----- rtl/fce_checker.sv -----
// port-level checker for the field convergence error check
// bound to field_convergence_error_check; uses no package
`default_nettype none
module fce_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last_node,
	input wire logic result_valid,
	input wire logic converged,
	input wire logic bad_divisor,
	input wire logic [31:0] error_metric
);
	// a last item makes the block busy next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_node |=> busy) else $error("no busy after last item");
	// an item that is not last leaves the block free
	a_mid_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_node |=> !busy) else $error("busy after mid item");
	// a result comes while busy ends
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy) && !busy) else $error("result outside busy end");
	// bad divisor clears converged and metric
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_divisor |-> !converged && error_metric == 32'd0)
		else $error("bad divisor result malformed");
endmodule

bind field_convergence_error_check fce_checker u_fce_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .last_node(last_node),
	.result_valid(result_valid), .converged(converged), .bad_divisor(bad_divisor),
	.error_metric(error_metric)
);
`default_nettype wire
